// ----- sv/ccwa_pkg.sv -----
// shared types, constants and calendar helpers for the calendar clock
// used by ccwa_step and calendar_clock_with_alarm; no dependencies
package ccwa_pkg;

  // item kinds on the input stream
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_TIME = 2'd1;
  localparam logic [1:0] OP_SET_DATE = 2'd2;

  // configuration register indexes
  localparam logic CFG_ALARM_HOUR   = 1'b0;
  localparam logic CFG_ALARM_MINUTE = 1'b1;

  // limits of the counters
  localparam logic [5:0] SECOND_MAX = 6'd59;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_FEB  = 4'd2;

  // reset values
  localparam logic [5:0] SECOND_RST       = 6'd0;
  localparam logic [5:0] MINUTE_RST       = 6'd0;
  localparam logic [4:0] HOUR_RST         = 5'd23;
  localparam logic [4:0] DAY_RST          = 5'd19;
  localparam logic [3:0] MONTH_RST        = 4'd6;
  localparam logic [6:0] YEAR_RST         = 7'd11;
  localparam logic [4:0] ALARM_HOUR_RST   = 5'd23;
  localparam logic [5:0] ALARM_MINUTE_RST = 6'd1;

  // clock and calendar counters
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } ccwa_time_t;

  // one result item
  typedef struct packed {
    ccwa_time_t tm;
    logic [2:0] weekday;
    logic       alarm_match;
    logic       write_error;
  } ccwa_result_t;

  // every year divisible by four is a leap year
  function automatic logic is_leap(input logic [6:0] year);
    is_leap = (year[1:0] == 2'd0);
  endfunction

  // length of a month; codes outside 1..12 are never used as a real month
  function automatic logic [4:0] month_days(input logic [6:0] year, input logic [3:0] month);
    case (month)
      4'd2:                      month_days = is_leap(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

  // days before the month in a common year, reduced modulo 7
  function automatic logic [2:0] month_start_mod7(input logic [3:0] month);
    case (month)
      4'd1:    month_start_mod7 = 3'd0;
      4'd2:    month_start_mod7 = 3'd3;
      4'd3:    month_start_mod7 = 3'd3;
      4'd4:    month_start_mod7 = 3'd6;
      4'd5:    month_start_mod7 = 3'd1;
      4'd6:    month_start_mod7 = 3'd4;
      4'd7:    month_start_mod7 = 3'd6;
      4'd8:    month_start_mod7 = 3'd2;
      4'd9:    month_start_mod7 = 3'd5;
      4'd10:   month_start_mod7 = 3'd0;
      4'd11:   month_start_mod7 = 3'd3;
      4'd12:   month_start_mod7 = 3'd5;
      default: month_start_mod7 = 3'd0;
    endcase
  endfunction

  // modulo 7 of a byte by folding octal digits (8 is 1 mod 7)
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [5:0] f1;
    logic [3:0] f2;
    f1 = 6'(x[7:3]) + 6'(x[2:0]);
    f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
    mod7 = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
  endfunction

endpackage

// ----- sv/ccwa_step.sv -----
// next counter state and result item for one input item
// depends on ccwa_pkg
module ccwa_step import ccwa_pkg::*; (
  input  ccwa_time_t   cur,
  input  logic [4:0]   alarm_hour,
  input  logic [5:0]   alarm_minute,
  input  logic [1:0]   opcode,
  input  logic [4:0]   new_hour,
  input  logic [5:0]   new_minute,
  input  logic [5:0]   new_second,
  input  logic [6:0]   new_year,
  input  logic [3:0]   new_month,
  input  logic [4:0]   new_day,
  output ccwa_time_t   nxt,
  output ccwa_result_t res
);

  logic       time_ok;
  logic       date_ok;
  logic       err;
  logic [6:0] year_m1;
  logic [7:0] day_sum;
  logic       leap_adj;

  // range checks for the set items
  assign time_ok = (new_hour <= HOUR_MAX) && (new_minute <= MINUTE_MAX) &&
                   (new_second <= SECOND_MAX);
  assign date_ok = (new_year <= YEAR_MAX) && (new_month != 4'd0) &&
                   (new_month <= MONTH_MAX) && (new_day != 5'd0) &&
                   (new_day <= month_days(new_year, new_month));

  // counter update: tick ripples through the carry chain of the calendar
  always_comb begin
    nxt = cur;
    err = 1'b0;
    case (opcode)
      OP_TICK: begin
        if (cur.second != SECOND_MAX) begin
          nxt.second = cur.second + 6'd1;
        end else begin
          nxt.second = 6'd0;
          if (cur.minute != MINUTE_MAX) begin
            nxt.minute = cur.minute + 6'd1;
          end else begin
            nxt.minute = 6'd0;
            if (cur.hour != HOUR_MAX) begin
              nxt.hour = cur.hour + 5'd1;
            end else begin
              nxt.hour = 5'd0;
              if (cur.day != month_days(cur.year, cur.month)) begin
                nxt.day = cur.day + 5'd1;
              end else begin
                nxt.day = 5'd1;
                if (cur.month != MONTH_MAX) begin
                  nxt.month = cur.month + 4'd1;
                end else begin
                  nxt.month = 4'd1;
                  nxt.year  = (cur.year == YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
                end
              end
            end
          end
        end
      end
      OP_SET_TIME: begin
        if (time_ok) begin
          nxt.hour   = new_hour;
          nxt.minute = new_minute;
          nxt.second = new_second;
        end else begin
          err = 1'b1;
        end
      end
      OP_SET_DATE: begin
        if (date_ok) begin
          nxt.year  = new_year;
          nxt.month = new_month;
          nxt.day   = new_day;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // weekday: 365 is 1 mod 7, so each full year adds one plus one per leap year
  assign year_m1  = (nxt.year == 7'd0) ? 7'd0 : nxt.year - 7'd1;
  assign leap_adj = (nxt.month > MONTH_FEB) && is_leap(nxt.year);
  assign day_sum  = 8'(year_m1) + 8'(year_m1[6:2]) + 8'(month_start_mod7(nxt.month)) +
                    8'(leap_adj) + 8'(nxt.day);

  // result item
  always_comb begin
    res.tm          = nxt;
    res.weekday     = mod7(day_sum);
    res.alarm_match = (nxt.hour == alarm_hour) && (nxt.minute == alarm_minute);
    res.write_error = err;
  end

endmodule

// ----- sv/calendar_clock_with_alarm.sv -----
// top level of the calendar clock with hour/minute alarm
// depends on ccwa_pkg and ccwa_step
//
//  channel | dir | transfer when          | payload
//  s_      | in  | s_tvalid && s_tready  | tuser: opcode; tdata: new time and date
//  m_      | out | m_tvalid && m_tready  | tdata: time, date, weekday; tuser: flags
//  cfg_    | in  | cfg_we                | cfg_index selects alarm hour or minute
//
// one item per cycle while s_tready is high; each result is registered in the output stage.
// the whole update and weekday sum sit between the counters and the result register.
// a two-entry output stage (result register plus skid register) keeps s_tready
// registered; s_tready drops only while the skid register is full.
// rst puts the counters at 23:00:00 on year 11 month 6 day 19, alarm at 23:01.
module calendar_clock_with_alarm import ccwa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] new_hour, [10:5] new_minute, [16:11] new_second, [23:17] new_year,
  // [27:24] new_month, [32:28] new_day, [39:33] zero
  input  logic [39:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [4:0] cur_hour, [10:5] cur_minute, [16:11] cur_second, [23:17] cur_year,
  // [27:24] cur_month, [32:28] cur_day, [35:33] weekday, [39:36] zero
  output logic [39:0] m_tdata,
  // [0] alarm_match, [1] write_error
  output logic [1:0]  m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  ccwa_time_t   cnt;
  ccwa_time_t   cnt_next;
  ccwa_result_t res_next;
  ccwa_result_t out_reg;
  ccwa_result_t skid_reg;
  logic         out_valid;
  logic         skid_valid;
  logic [4:0]   alarm_hour;
  logic [5:0]   alarm_minute;
  logic         s_fire;
  logic         m_fire;

  assign s_tready = !skid_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = out_valid && m_tready;

  // alarm registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_hour   <= ALARM_HOUR_RST;
      alarm_minute <= ALARM_MINUTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALARM_HOUR:   alarm_hour   <= cfg_data[4:0];
        CFG_ALARM_MINUTE: alarm_minute <= cfg_data;
        default:          alarm_minute <= alarm_minute;
      endcase
    end
  end

  // per-item update logic
  ccwa_step u_step (
    .cur          (cnt),
    .alarm_hour   (alarm_hour),
    .alarm_minute (alarm_minute),
    .opcode       (s_tuser),
    .new_hour     (s_tdata[4:0]),
    .new_minute   (s_tdata[10:5]),
    .new_second   (s_tdata[16:11]),
    .new_year     (s_tdata[23:17]),
    .new_month    (s_tdata[27:24]),
    .new_day      (s_tdata[32:28]),
    .nxt          (cnt_next),
    .res          (res_next)
  );

  // clock and calendar counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt.hour   <= HOUR_RST;
      cnt.minute <= MINUTE_RST;
      cnt.second <= SECOND_RST;
      cnt.year   <= YEAR_RST;
      cnt.month  <= MONTH_RST;
      cnt.day    <= DAY_RST;
    end else if (s_fire) begin
      cnt <= cnt_next;
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s_fire;
      end
    end else if (s_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (!out_valid || m_fire) begin
      out_reg <= skid_valid ? skid_reg : res_next;
    end else if (s_fire) begin
      skid_reg <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_reg.weekday, out_reg.tm.day, out_reg.tm.month,
                     out_reg.tm.year, out_reg.tm.second, out_reg.tm.minute,
                     out_reg.tm.hour};
  assign m_tuser  = {out_reg.write_error, out_reg.alarm_match};

endmodule
